// ===== design/rmq_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion block.
package rmq_pkg;

    // Width of every matrix element and quaternion component.
    localparam int ELEM_W = 18;
    // Width of an off-diagonal sum or difference, and of its magnitude.
    localparam int NUM_W = ELEM_W + 1;
    // Quotient bits developed by the divider; the top one flags saturation.
    localparam int QUO_W = ELEM_W;

    localparam logic signed [ELEM_W-1:0] OUT_MAX = 18'sh1FFFF;
    localparam logic signed [ELEM_W-1:0] OUT_MIN = 18'sh20000;

    // Which component comes from the square root.
    typedef logic [1:0] t_sel;
    localparam t_sel SEL_W = 2'd0;
    localparam t_sel SEL_X = 2'd1;
    localparam t_sel SEL_Y = 2'd2;
    localparam t_sel SEL_Z = 2'd3;

    typedef logic [NUM_W-1:0] t_mag;

endpackage

// ===== design/rmq_front.sv =====
// Input cell: picks the branch, forms the radicand and the three numerators.
module rmq_front #(
    parameter int FRAC_BITS = 16,
    parameter int RB = 22,
    parameter int NW = 38
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic signed [rmq_pkg::ELEM_W-1:0]     i_a [9],
    output logic                                  o_valid,
    output logic [NW-1:0]                         o_rad,
    output rmq_pkg::t_sel                         o_sel,
    output logic                                  o_deg,
    output logic [2:0]                            o_neg,
    output rmq_pkg::t_mag                         o_mag [3]
);
    import rmq_pkg::*;

    logic signed [RB-1:0]    m [9];
    logic signed [RB-1:0]    one;
    logic signed [RB-1:0]    trace;
    logic signed [RB-1:0]    r;
    logic signed [NUM_W-1:0] n [3];
    t_sel                    sel;

    logic                    r_valid;
    logic [NW-1:0]           r_rad;
    t_sel                    r_sel;
    logic                    r_deg;
    logic [2:0]              r_neg;
    t_mag                    r_mag [3];

    // Sign-extend the elements and choose the branch.
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            m[k] = RB'(i_a[k]);
        end
        one   = RB'(1) <<< FRAC_BITS;
        trace = m[0] + m[4] + m[8];
        if (trace > 0) begin
            sel  = SEL_W;
            r    = one + trace;
            n[0] = NUM_W'(i_a[7]) - NUM_W'(i_a[5]);
            n[1] = NUM_W'(i_a[2]) - NUM_W'(i_a[6]);
            n[2] = NUM_W'(i_a[3]) - NUM_W'(i_a[1]);
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            sel  = SEL_X;
            r    = one + m[0] - m[4] - m[8];
            n[0] = NUM_W'(i_a[7]) - NUM_W'(i_a[5]);
            n[1] = NUM_W'(i_a[3]) + NUM_W'(i_a[1]);
            n[2] = NUM_W'(i_a[2]) + NUM_W'(i_a[6]);
        end else if (m[4] > m[8]) begin
            sel  = SEL_Y;
            r    = one - m[0] + m[4] - m[8];
            n[0] = NUM_W'(i_a[2]) - NUM_W'(i_a[6]);
            n[1] = NUM_W'(i_a[3]) + NUM_W'(i_a[1]);
            n[2] = NUM_W'(i_a[7]) + NUM_W'(i_a[5]);
        end else begin
            sel  = SEL_Z;
            r    = one - m[0] - m[4] + m[8];
            n[0] = NUM_W'(i_a[3]) - NUM_W'(i_a[1]);
            n[1] = NUM_W'(i_a[2]) + NUM_W'(i_a[6]);
            n[2] = NUM_W'(i_a[5]) + NUM_W'(i_a[7]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload: radicand scaled by one, branch select, degenerate flag, numerator signs and magnitudes.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad <= NW'(r[RB-2:0]) << FRAC_BITS;
            r_sel <= sel;
            r_deg <= (r <= 0);
            for (int k = 0; k < 3; k++) begin
                r_neg[k] <= n[k][NUM_W-1];
                r_mag[k] <= n[k][NUM_W-1] ? t_mag'(-n[k]) : t_mag'(n[k]);
            end
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_sel   = r_sel;
    assign o_deg   = r_deg;
    assign o_neg   = r_neg;
    assign o_mag   = r_mag;
endmodule

// ===== design/rmq_sqrt_cell.sv =====
// Square root cell: develops one root bit from two radicand bits.
module rmq_sqrt_cell #(
    parameter int SQ = 19,
    parameter int NW = 38,
    parameter int SW = 63
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_rad,
    input  logic [SQ+1:0] i_rem,
    input  logic [SQ-1:0] i_root,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_rad,
    output logic [SQ+1:0] o_rem,
    output logic [SQ-1:0] o_root,
    output logic [SW-1:0] o_side
);
    logic [SQ+3:0] rem2;
    logic [SQ+3:0] trial;
    logic [SQ+3:0] diff;
    logic          ge;

    logic          r_valid;
    logic [NW-1:0] r_rad;
    logic [SQ+1:0] r_rem;
    logic [SQ-1:0] r_root;
    logic [SW-1:0] r_side;

    // Restoring step: try root*4+1 against the remainder.
    always_comb begin
        rem2  = {i_rem, i_rad[NW-1 -: 2]};
        trial = {2'b00, i_root, 2'b01};
        diff  = rem2 - trial;
        ge    = (rem2 >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= i_rad << 2;
            r_rem  <= ge ? diff[SQ+1:0] : rem2[SQ+1:0];
            r_root <= {i_root[SQ-2:0], ge};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;
endmodule

// ===== design/rmq_div_cell.sv =====
// Divider cell: develops one quotient bit in each of three lanes.
module rmq_div_cell #(
    parameter int W   = 56,
    parameter int BIT = 17,
    parameter int SQ  = 19,
    parameter int SW  = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [W-1:0]                 i_div,
    input  logic [SQ-1:0]                i_root,
    input  logic [W-1:0]                 i_rem [3],
    input  logic [rmq_pkg::QUO_W-1:0]    i_quo [3],
    input  logic [SW-1:0]                i_side,
    output logic                         o_valid,
    output logic [W-1:0]                 o_div,
    output logic [SQ-1:0]                o_root,
    output logic [W-1:0]                 o_rem [3],
    output logic [rmq_pkg::QUO_W-1:0]    o_quo [3],
    output logic [SW-1:0]                o_side
);
    import rmq_pkg::*;

    logic [W-1:0]     shifted;
    logic [2:0]       ge;

    logic             r_valid;
    logic [W-1:0]     r_div;
    logic [SQ-1:0]    r_root;
    logic [W-1:0]     r_rem [3];
    logic [QUO_W-1:0] r_quo [3];
    logic [SW-1:0]    r_side;

    // Compare each remainder with the divisor at this bit weight.
    always_comb begin
        shifted = i_div << BIT;
        for (int k = 0; k < 3; k++) begin
            ge[k] = (i_rem[k] >= shifted);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div  <= i_div;
            r_root <= i_root;
            r_side <= i_side;
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= ge[k] ? (i_rem[k] - shifted) : i_rem[k];
                r_quo[k] <= {i_quo[k][QUO_W-2:0], ge[k]};
            end
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_root  = r_root;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_side  = r_side;
endmodule

// ===== design/rotation_matrix_to_quaternion_top.sv =====
// Top level of the rotation matrix to quaternion converter.
// Converts a 3x3 rotation matrix (18-bit signed, FRAC_BITS fraction bits) to a quaternion by
// Shepperd's method and takes one matrix transfer per clock cycle unless the output is stalled.
// The chain is one input cell, one square root cell per root bit, eighteen divider cells that
// each develop one quotient bit for all three off-diagonal components, and an output register.
// The whole chain advances together and holds while the output transfer is stalled. A
// non-positive radicand gives a zero quaternion with the degenerate flag set in m_axis_tuser.
module rotation_matrix_to_quaternion_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a00, a01, a02, a10, a11, a12, a20, a21, a22 (18 bits each), then six zero bits
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z (18 bits each)
    output logic [71:0]  m_axis_tdata,
    // degenerate
    output logic         m_axis_tuser
);
    import rmq_pkg::*;

    localparam int RB = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 3;
    localparam int NB = RB - 1 + FRAC_BITS;
    localparam int SQ = (NB + 1) / 2;
    localparam int NW = 2 * SQ;
    localparam int DW = NUM_W + FRAC_BITS;
    localparam int W  = ((DW > SQ + 1 + QUO_W) ? DW : SQ + 1 + QUO_W) + 1;
    // Side data through the root cells: magnitudes, signs, degenerate, select.
    localparam int DSW = 3 + 1 + 2;
    localparam int SSW = 3 * NUM_W + DSW;

    logic                     en;
    logic signed [ELEM_W-1:0] a [9];

    logic                     f_valid;
    logic [NW-1:0]            f_rad;
    t_sel                     f_sel;
    logic                     f_deg;
    logic [2:0]               f_neg;
    t_mag                     f_mag [3];

    logic                     s_valid [SQ+1];
    logic [NW-1:0]            s_rad   [SQ+1];
    logic [SQ+1:0]            s_rem   [SQ+1];
    logic [SQ-1:0]            s_root  [SQ+1];
    logic [SSW-1:0]           s_side  [SQ+1];

    logic                     d_valid [QUO_W+1];
    logic [W-1:0]             d_div   [QUO_W+1];
    logic [SQ-1:0]            d_root  [QUO_W+1];
    logic [W-1:0]             d_rem   [QUO_W+1][3];
    logic [QUO_W-1:0]         d_quo   [QUO_W+1][3];
    logic [DSW-1:0]           d_side  [QUO_W+1];

    logic signed [ELEM_W-1:0] oth [3];
    logic signed [ELEM_W-1:0] rootc;
    logic signed [ELEM_W-1:0] n_q [4];
    t_sel                     l_sel;
    logic                     l_deg;
    logic [2:0]               l_neg;

    logic                     r_valid;
    logic [71:0]              r_data;
    logic                     r_deg;

    // The chain moves whenever the output register is free or being emptied.
    assign en            = !r_valid || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            a[k] = s_axis_tdata[k*ELEM_W +: ELEM_W];
        end
    end

    rmq_front #(.FRAC_BITS(FRAC_BITS), .RB(RB), .NW(NW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_a     (a),
        .o_valid (f_valid),
        .o_rad   (f_rad),
        .o_sel   (f_sel),
        .o_deg   (f_deg),
        .o_neg   (f_neg),
        .o_mag   (f_mag)
    );

    // Square root chain, one root bit per cell.
    assign s_valid[0] = f_valid;
    assign s_rad[0]   = f_rad;
    assign s_rem[0]   = '0;
    assign s_root[0]  = '0;
    assign s_side[0]  = {f_mag[2], f_mag[1], f_mag[0], f_neg, f_deg, f_sel};

    for (genvar g = 0; g < SQ; g++) begin : g_sqrt
        rmq_sqrt_cell #(.SQ(SQ), .NW(NW), .SW(SSW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s_valid[g]),
            .i_rad   (s_rad[g]),
            .i_rem   (s_rem[g]),
            .i_root  (s_root[g]),
            .i_side  (s_side[g]),
            .o_valid (s_valid[g+1]),
            .o_rad   (s_rad[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_root  (s_root[g+1]),
            .o_side  (s_side[g+1])
        );
    end

    // Divider chain: numerator * one / (2 * root), most significant bit first.
    assign d_valid[0] = s_valid[SQ];
    assign d_div[0]   = W'({s_root[SQ], 1'b0});
    assign d_root[0]  = s_root[SQ];
    assign d_side[0]  = s_side[SQ][DSW-1:0];
    for (genvar k = 0; k < 3; k++) begin : g_lane
        assign d_rem[0][k] = W'(s_side[SQ][DSW + k*NUM_W +: NUM_W]) << FRAC_BITS;
        assign d_quo[0][k] = '0;
    end

    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        rmq_div_cell #(.W(W), .BIT(QUO_W - 1 - g), .SQ(SQ), .SW(DSW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (d_valid[g]),
            .i_div   (d_div[g]),
            .i_root  (d_root[g]),
            .i_rem   (d_rem[g]),
            .i_quo   (d_quo[g]),
            .i_side  (d_side[g]),
            .o_valid (d_valid[g+1]),
            .o_div   (d_div[g+1]),
            .o_root  (d_root[g+1]),
            .o_rem   (d_rem[g+1]),
            .o_quo   (d_quo[g+1]),
            .o_side  (d_side[g+1])
        );
    end

    // Apply signs, saturate, place the root component and zero a degenerate result.
    always_comb begin
        l_sel = d_side[QUO_W][1:0];
        l_deg = d_side[QUO_W][2];
        l_neg = d_side[QUO_W][5:3];
        for (int k = 0; k < 3; k++) begin
            if (d_quo[QUO_W][k][QUO_W-1]) begin
                oth[k] = l_neg[k] ? OUT_MIN : OUT_MAX;
            end else if (l_neg[k]) begin
                oth[k] = -$signed(d_quo[QUO_W][k]);
            end else begin
                oth[k] = $signed(d_quo[QUO_W][k]);
            end
        end
        if ((d_root[QUO_W] >> 1) > SQ'(OUT_MAX)) begin
            rootc = OUT_MAX;
        end else begin
            rootc = ELEM_W'(d_root[QUO_W] >> 1);
        end
        case (l_sel)
            SEL_W: begin
                n_q[0] = rootc;  n_q[1] = oth[0]; n_q[2] = oth[1]; n_q[3] = oth[2];
            end
            SEL_X: begin
                n_q[0] = oth[0]; n_q[1] = rootc;  n_q[2] = oth[1]; n_q[3] = oth[2];
            end
            SEL_Y: begin
                n_q[0] = oth[0]; n_q[1] = oth[1]; n_q[2] = rootc;  n_q[3] = oth[2];
            end
            default: begin
                n_q[0] = oth[0]; n_q[1] = oth[1]; n_q[2] = oth[2]; n_q[3] = rootc;
            end
        endcase
        if (l_deg) begin
            for (int k = 0; k < 4; k++) begin
                n_q[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= d_valid[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_data <= {n_q[3], n_q[2], n_q[1], n_q[0]};
            r_deg  <= l_deg;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;
    assign m_axis_tuser  = r_deg;
endmodule
